/* sv/kmc_pkg.sv */
package kmc_pkg;

  // Default grid limits; the top level takes them as parameter defaults.
  localparam int DEF_MAX_CELL_ROWS = 32;
  localparam int DEF_MAX_CELL_COLS = 32;

  // Fixed field and port widths.
  localparam int CFG_W        = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 8;
  localparam int QUEUE_DEPTH  = 2;
  localparam int CARVE_LEN    = 3;

  localparam logic [CFG_W-1:0] DIM_RESET = 6'd31;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  // Request codes on the input channel.
  localparam logic [1:0] REQ_INIT = 2'd0;
  localparam logic [1:0] REQ_EDGE = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EDGE_OUT = 2'd1;
  localparam logic [1:0] ST_READ_OUT = 2'd2;

  // Work kinds handed from the front end to the back end.
  localparam logic [1:0] KIND_INIT = 2'd0;
  localparam logic [1:0] KIND_EDGE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
    logic       vert;
  } kmc_cmd_t;

  typedef struct packed {
    logic       accepted;
    logic       cell_value;
    logic [1:0] status;
  } kmc_res_t;

  // A zero dimension counts as one and anything above the limit as the limit.
  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input int unsigned maxv);
    int unsigned vi;
    vi = 32'(v);
    if (vi == 0) return 6'd1;
    else if (vi > maxv) return CFG_W'(maxv);
    else return v;
  endfunction

endpackage

/* sv/kmc_ram.sv */
module kmc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/kmc_queue.sv */
module kmc_queue
  import kmc_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             ready,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             valid
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign dout  = ent_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= din;
    end
  end

endmodule

/* sv/kmc_front.sv */
module kmc_front
  import kmc_pkg::*;
#(
  parameter int MAX_CELL_ROWS = DEF_MAX_CELL_ROWS,
  parameter int MAX_CELL_COLS = DEF_MAX_CELL_COLS,
  localparam int CELL_N  = MAX_CELL_ROWS * MAX_CELL_COLS,
  localparam int MAZE_W  = 2 * MAX_CELL_COLS + 1,
  localparam int MAZE_N  = MAZE_W * (2 * MAX_CELL_ROWS + 1),
  localparam int CIDX_W  = (CELL_N > 1) ? $clog2(CELL_N) : 1,
  localparam int MADDR_W = $clog2(MAZE_N)
) (
  input  logic [1:0]         req_type,
  input  logic [4:0]         cell_row,
  input  logic [4:0]         cell_col,
  input  logic               orientation,
  input  logic [6:0]         grid_y,
  input  logic [6:0]         grid_x,
  input  logic [CFG_W-1:0]   rows,
  input  logic [CFG_W-1:0]   cols,
  output kmc_cmd_t           cmd,
  output logic [CIDX_W-1:0]  cell_a,
  output logic [CIDX_W-1:0]  cell_b,
  output logic [MADDR_W-1:0] maze_addr
);

  logic [5:0]  nbr_row;
  logic [5:0]  nbr_col;
  logic        edge_bad;
  logic        read_bad;
  logic [6:0]  maze_row;
  logic [6:0]  maze_col;
  logic [31:0] a_full;
  logic [31:0] b_full;
  logic [31:0] m_full;

  // Bounds checks for edge offers and maze reads.
  assign nbr_row  = {1'b0, cell_row} + 6'(orientation);
  assign nbr_col  = {1'b0, cell_col} + 6'(!orientation);
  assign edge_bad = ({1'b0, cell_row} >= rows) || ({1'b0, cell_col} >= cols) ||
                    (nbr_row >= rows) || (nbr_col >= cols);
  assign read_bad = ({1'b0, grid_y} >= {1'b0, rows, 1'b1}) ||
                    ({1'b0, grid_x} >= {1'b0, cols, 1'b1});

  // Cell label addresses of the two cells of an edge.
  assign a_full = 32'(cell_row) * 32'(MAX_CELL_COLS) + 32'(cell_col);
  assign b_full = a_full + (orientation ? 32'(MAX_CELL_COLS) : 32'd1);
  assign cell_a = a_full[CIDX_W-1:0];
  assign cell_b = b_full[CIDX_W-1:0];

  // Maze address: the first carved bit for an edge, the read bit otherwise.
  assign maze_row  = (req_type == REQ_EDGE) ? {1'b0, cell_row, 1'b1} : grid_y;
  assign maze_col  = (req_type == REQ_EDGE) ? {1'b0, cell_col, 1'b1} : grid_x;
  assign m_full    = 32'(maze_row) * 32'(MAZE_W) + 32'(maze_col);
  assign maze_addr = m_full[MADDR_W-1:0];

  // Classify the request; anything that needs no store access is finished here.
  always_comb begin
    cmd.vert = orientation;
    unique case (req_type)
      REQ_INIT: begin
        cmd.kind   = KIND_INIT;
        cmd.status = ST_OK;
      end
      REQ_EDGE: begin
        cmd.kind   = edge_bad ? KIND_DONE : KIND_EDGE;
        cmd.status = edge_bad ? ST_EDGE_OUT : ST_OK;
      end
      REQ_READ: begin
        cmd.kind   = read_bad ? KIND_DONE : KIND_READ;
        cmd.status = read_bad ? ST_READ_OUT : ST_OK;
      end
      default: begin
        cmd.kind   = KIND_DONE;
        cmd.status = ST_OK;
      end
    endcase
  end

endmodule

/* sv/kmc_back.sv */
module kmc_back
  import kmc_pkg::*;
#(
  parameter int MAX_CELL_ROWS = DEF_MAX_CELL_ROWS,
  parameter int MAX_CELL_COLS = DEF_MAX_CELL_COLS,
  localparam int CELL_N  = MAX_CELL_ROWS * MAX_CELL_COLS,
  localparam int MAZE_W  = 2 * MAX_CELL_COLS + 1,
  localparam int MAZE_N  = MAZE_W * (2 * MAX_CELL_ROWS + 1),
  localparam int CIDX_W  = (CELL_N > 1) ? $clog2(CELL_N) : 1,
  localparam int MADDR_W = $clog2(MAZE_N),
  localparam int ROW_W   = (MAX_CELL_ROWS > 1) ? $clog2(MAX_CELL_ROWS) : 1,
  localparam int COL_W   = (MAX_CELL_COLS > 1) ? $clog2(MAX_CELL_COLS) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CFG_W-1:0]   rows,
  input  logic [CFG_W-1:0]   cols,
  input  logic               q_valid,
  input  kmc_cmd_t           q_cmd,
  input  logic [CIDX_W-1:0]  q_cell_a,
  input  logic [CIDX_W-1:0]  q_cell_b,
  input  logic [MADDR_W-1:0] q_maze_addr,
  output logic               q_pop,
  output logic               boot_busy,
  output logic               out_valid,
  input  logic               out_ready,
  output kmc_res_t           out_res
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LA    = 4'd2;
  localparam logic [3:0] S_LB    = 4'd3;
  localparam logic [3:0] S_SWEEP = 4'd4;
  localparam logic [3:0] S_DRAIN = 4'd5;
  localparam logic [3:0] S_CARVE = 4'd6;
  localparam logic [3:0] S_READ  = 4'd7;
  localparam logic [3:0] S_RESP  = 4'd8;

  logic [3:0]         state_r, state_nxt;
  logic               boot_r, boot_nxt;
  logic               out_valid_r, out_valid_nxt;
  kmc_res_t           out_res_r, out_res_nxt;
  kmc_res_t           res_r, res_nxt;
  logic [MADDR_W-1:0] clr_r, clr_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic [CIDX_W-1:0]  pend_idx_r, pend_idx_nxt;
  logic               pend_use_r, pend_use_nxt;
  logic [CIDX_W-1:0]  sw_idx_r, sw_idx_nxt;
  logic [ROW_W-1:0]   sw_row_r, sw_row_nxt;
  logic [COL_W-1:0]   sw_col_r, sw_col_nxt;
  logic [CIDX_W-1:0]  cell_b_r, cell_b_nxt;
  logic [MADDR_W-1:0] carve_addr_r, carve_addr_nxt;
  logic [1:0]         carve_cnt_r, carve_cnt_nxt;
  logic               vert_r, vert_nxt;
  logic [CIDX_W-1:0]  keep_r, keep_nxt;
  logic [CIDX_W-1:0]  gone_r, gone_nxt;

  logic               lab_we;
  logic [CIDX_W-1:0]  lab_waddr;
  logic [CIDX_W-1:0]  lab_wdata;
  logic [CIDX_W-1:0]  lab_raddr;
  logic [CIDX_W-1:0]  lab_rdata;
  logic               maze_we;
  logic [MADDR_W-1:0] maze_waddr;
  logic               maze_wdata;
  logic [MADDR_W-1:0] maze_raddr;
  logic               maze_rdata;
  logic               sw_in_use;
  logic               out_free;

  // Set labels, one for every cell.
  kmc_ram #(.WIDTH(CIDX_W), .DEPTH(CELL_N)) u_label_ram (
    .clk   (clk),
    .we    (lab_we),
    .waddr (lab_waddr),
    .wdata (lab_wdata),
    .raddr (lab_raddr),
    .rdata (lab_rdata)
  );

  // Maze bits, one for every maze position.
  kmc_ram #(.WIDTH(1), .DEPTH(MAZE_N)) u_maze_ram (
    .clk   (clk),
    .we    (maze_we),
    .waddr (maze_waddr),
    .wdata (maze_wdata),
    .raddr (maze_raddr),
    .rdata (maze_rdata)
  );

  assign boot_busy = boot_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign sw_in_use = (9'(sw_row_r) < 9'(rows)) && (9'(sw_col_r) < 9'(cols));

  // Label memory port selection: clearing pass, edge label lookups, or relabel sweep.
  always_comb begin
    lab_we    = 1'b0;
    lab_waddr = pend_idx_r;
    lab_wdata = keep_r;
    lab_raddr = '0;
    if (state_r == S_CLEAR) begin
      lab_we    = (clr_r < MADDR_W'(CELL_N));
      lab_waddr = clr_r[CIDX_W-1:0];
      lab_wdata = clr_r[CIDX_W-1:0];
    end else if ((state_r == S_SWEEP) || (state_r == S_DRAIN)) begin
      lab_we = pend_valid_r && pend_use_r && (lab_rdata == gone_r);
    end
    if (state_r == S_IDLE) begin
      lab_raddr = q_cell_a;
    end else if (state_r == S_LA) begin
      lab_raddr = cell_b_r;
    end else if (state_r == S_SWEEP) begin
      lab_raddr = sw_idx_r;
    end
  end

  // Maze memory port selection: clearing pass to walls, carving to path.
  always_comb begin
    maze_we    = 1'b0;
    maze_waddr = carve_addr_r;
    maze_wdata = 1'b0;
    maze_raddr = q_maze_addr;
    if (state_r == S_CLEAR) begin
      maze_we    = 1'b1;
      maze_waddr = clr_r;
      maze_wdata = 1'b1;
    end else if (state_r == S_CARVE) begin
      maze_we = 1'b1;
    end
  end

  // Sequencer for one request at a time.
  always_comb begin
    state_nxt      = state_r;
    boot_nxt       = boot_r;
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    res_nxt        = res_r;
    clr_nxt        = clr_r;
    pend_valid_nxt = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    pend_use_nxt   = pend_use_r;
    sw_idx_nxt     = sw_idx_r;
    sw_row_nxt     = sw_row_r;
    sw_col_nxt     = sw_col_r;
    cell_b_nxt     = cell_b_r;
    carve_addr_nxt = carve_addr_r;
    carve_cnt_nxt  = carve_cnt_r;
    vert_nxt       = vert_r;
    keep_nxt       = keep_r;
    gone_nxt       = gone_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == MADDR_W'(MAZE_N - 1)) begin
          clr_nxt = '0;
          res_nxt = '{accepted: 1'b0, cell_value: 1'b0, status: ST_OK};
          if (boot_r) begin
            boot_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          cell_b_nxt     = q_cell_b;
          carve_addr_nxt = q_maze_addr;
          vert_nxt       = q_cmd.vert;
          unique case (q_cmd.kind)
            KIND_INIT: state_nxt = S_CLEAR;
            KIND_EDGE: state_nxt = S_LA;
            KIND_READ: state_nxt = S_READ;
            default: begin
              res_nxt   = '{accepted: 1'b0, cell_value: 1'b0, status: q_cmd.status};
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_LA: begin
        keep_nxt  = lab_rdata;
        state_nxt = S_LB;
      end
      S_LB: begin
        gone_nxt   = lab_rdata;
        sw_idx_nxt = '0;
        sw_row_nxt = '0;
        sw_col_nxt = '0;
        if (lab_rdata == keep_r) begin
          res_nxt   = '{accepted: 1'b0, cell_value: 1'b0, status: ST_OK};
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        // Read one label per cycle; the compare and write follow in the next cycle.
        pend_valid_nxt = 1'b1;
        pend_idx_nxt   = sw_idx_r;
        pend_use_nxt   = sw_in_use;
        sw_idx_nxt     = sw_idx_r + 1'b1;
        if (sw_col_r == COL_W'(MAX_CELL_COLS - 1)) begin
          sw_col_nxt = '0;
          sw_row_nxt = sw_row_r + 1'b1;
        end else begin
          sw_col_nxt = sw_col_r + 1'b1;
        end
        if (sw_idx_r == CIDX_W'(CELL_N - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        carve_cnt_nxt = '0;
        state_nxt     = S_CARVE;
      end
      S_CARVE: begin
        carve_cnt_nxt  = carve_cnt_r + 1'b1;
        carve_addr_nxt = carve_addr_r + (vert_r ? MADDR_W'(MAZE_W) : MADDR_W'(1));
        if (carve_cnt_r == 2'(CARVE_LEN - 1)) begin
          res_nxt   = '{accepted: 1'b1, cell_value: 1'b0, status: ST_OK};
          state_nxt = S_RESP;
        end
      end
      S_READ: begin
        res_nxt   = '{accepted: 1'b0, cell_value: maze_rdata, status: ST_OK};
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      boot_r       <= 1'b1;
      out_valid_r  <= 1'b0;
      clr_r        <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      boot_r       <= boot_nxt;
      out_valid_r  <= out_valid_nxt;
      clr_r        <= clr_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_res_r    <= out_res_nxt;
    res_r        <= res_nxt;
    pend_idx_r   <= pend_idx_nxt;
    pend_use_r   <= pend_use_nxt;
    sw_idx_r     <= sw_idx_nxt;
    sw_row_r     <= sw_row_nxt;
    sw_col_r     <= sw_col_nxt;
    cell_b_r     <= cell_b_nxt;
    carve_addr_r <= carve_addr_nxt;
    carve_cnt_r  <= carve_cnt_nxt;
    vert_r       <= vert_nxt;
    keep_r       <= keep_nxt;
    gone_r       <= gone_nxt;
  end

  // Labels are only written by the clearing pass or the relabel sweep.
  a_label_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    lab_we |-> (state_r == S_CLEAR) || (state_r == S_SWEEP) || (state_r == S_DRAIN))
    else $error("label written outside clear or sweep");

  // A maze bit goes to path only while carving an accepted edge.
  a_path_only_carve: assert property (@(posedge clk) disable iff (!rst_n)
    (maze_we && !maze_wdata) |-> (state_r == S_CARVE))
    else $error("maze bit cleared outside carve");

  // A new result always comes out of the response step.
  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_RESP))
    else $error("result raised outside response step");

  // Carving never runs past its three maze bits.
  a_carve_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CARVE) |-> (carve_cnt_r < 2'(CARVE_LEN)))
    else $error("carve counter out of range");

endmodule

/* sv/kruskal_maze_carver_top.sv */
// Channel   Direction  Handshake              Payload
// in_       slave      in_tvalid / in_tready  tdata: cell_row, cell_col, orientation, grid_y,
//                                             grid_x; tuser: req_type
// out_      master     out_tvalid / out_tready tdata: accepted, cell_value; tuser: status
// cfg_      slave      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// After reset a clearing pass walls every maze bit and gives every cell its own label,
// one entry per cycle; in_tready stays low meanwhile. Requests run one at a time in the
// back end: an initialize request reruns the clearing pass, a read looks up one maze bit,
// a refused edge compares the labels of its two cells, an out-of-range edge goes straight
// to the response, and a merged edge relabels one set in a sweep over the whole label
// memory and then carves its three maze bits. A two-entry request queue lets the input
// side keep accepting while the back end works or a result waits on out_tready.
module kruskal_maze_carver_top
  import kmc_pkg::*;
#(
  parameter int MAX_CELL_ROWS = DEF_MAX_CELL_ROWS,
  parameter int MAX_CELL_COLS = DEF_MAX_CELL_COLS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [4:0] cell_row, [9:5] cell_col, [10] orientation, [17:11] grid_y, [24:18] grid_x
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] req_type
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] accepted, [1] cell_value
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [1:0]             out_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int CELL_N  = MAX_CELL_ROWS * MAX_CELL_COLS;
  localparam int MAZE_N  = (2 * MAX_CELL_COLS + 1) * (2 * MAX_CELL_ROWS + 1);
  localparam int CIDX_W  = (CELL_N > 1) ? $clog2(CELL_N) : 1;
  localparam int MADDR_W = $clog2(MAZE_N);
  localparam int CMD_W   = $bits(kmc_cmd_t);
  localparam int Q_W     = CMD_W + 2 * CIDX_W + MADDR_W;

  logic [CFG_W-1:0]   rows_cfg_r, rows_cfg_nxt;
  logic [CFG_W-1:0]   cols_cfg_r, cols_cfg_nxt;
  logic [CFG_W-1:0]   rows;
  logic [CFG_W-1:0]   cols;
  kmc_cmd_t           f_cmd;
  logic [CIDX_W-1:0]  f_cell_a;
  logic [CIDX_W-1:0]  f_cell_b;
  logic [MADDR_W-1:0] f_maze_addr;
  logic [Q_W-1:0]     q_din;
  logic [Q_W-1:0]     q_dout;
  logic               q_ready;
  logic               q_valid;
  logic               q_pop;
  kmc_cmd_t           q_cmd;
  logic [CIDX_W-1:0]  q_cell_a;
  logic [CIDX_W-1:0]  q_cell_b;
  logic [MADDR_W-1:0] q_maze_addr;
  logic               boot_busy;
  kmc_res_t           res;

  // Configuration registers; the stored value is clamped where it is used.
  assign cfg_ready = 1'b1;

  always_comb begin
    rows_cfg_nxt = rows_cfg_r;
    cols_cfg_nxt = cols_cfg_r;
    if (cfg_valid) begin
      if (cfg_index == CFG_ROWS) begin
        rows_cfg_nxt = cfg_data;
      end else if (cfg_index == CFG_COLS) begin
        cols_cfg_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= DIM_RESET;
      cols_cfg_r <= DIM_RESET;
    end else begin
      rows_cfg_r <= rows_cfg_nxt;
      cols_cfg_r <= cols_cfg_nxt;
    end
  end

  assign rows = clamp_dim(rows_cfg_r, MAX_CELL_ROWS);
  assign cols = clamp_dim(cols_cfg_r, MAX_CELL_COLS);

  // Front end: classify each request and work out its addresses.
  kmc_front #(
    .MAX_CELL_ROWS (MAX_CELL_ROWS),
    .MAX_CELL_COLS (MAX_CELL_COLS)
  ) u_front (
    .req_type    (in_tuser),
    .cell_row    (in_tdata[4:0]),
    .cell_col    (in_tdata[9:5]),
    .orientation (in_tdata[10]),
    .grid_y      (in_tdata[17:11]),
    .grid_x      (in_tdata[24:18]),
    .rows        (rows),
    .cols        (cols),
    .cmd         (f_cmd),
    .cell_a      (f_cell_a),
    .cell_b      (f_cell_b),
    .maze_addr   (f_maze_addr)
  );

  // Request queue between the two halves.
  assign in_tready = q_ready && !boot_busy;
  assign q_din     = {f_cmd, f_cell_a, f_cell_b, f_maze_addr};

  kmc_queue #(.WIDTH(Q_W)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_tvalid && in_tready),
    .din   (q_din),
    .ready (q_ready),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid)
  );

  assign {q_cmd, q_cell_a, q_cell_b, q_maze_addr} = q_dout;

  // Back end: store access, relabel sweep, carving and results.
  kmc_back #(
    .MAX_CELL_ROWS (MAX_CELL_ROWS),
    .MAX_CELL_COLS (MAX_CELL_COLS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .rows        (rows),
    .cols        (cols),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_cell_a    (q_cell_a),
    .q_cell_b    (q_cell_b),
    .q_maze_addr (q_maze_addr),
    .q_pop       (q_pop),
    .boot_busy   (boot_busy),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_res     (res)
  );

  assign out_tdata = {{(OUT_TDATA_W - 2){1'b0}}, res.cell_value, res.accepted};
  assign out_tuser = res.status;

endmodule

/* test/testbench.sv */
module testbench;
  import kmc_pkg::*;

  localparam int MAX_ROWS = DEF_MAX_CELL_ROWS;
  localparam int MAX_COLS = DEF_MAX_CELL_COLS;
  localparam int MAZE_W = 2 * MAX_COLS + 1;
  localparam int MAZE_H = 2 * MAX_ROWS + 1;
  localparam int RAND_TARGET = 520;
  localparam int HOLD_CYCLES = 300;

  // Request code that the block ignores, and register indexes with no register behind them.
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct {
    logic [1:0] req;
    logic [4:0] row;
    logic [4:0] col;
    logic       down;
    logic [6:0] gy;
    logic [6:0] gx;
  } carve_req_t;

  logic clk;
  logic rst_n;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  kruskal_maze_carver_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the carver's registers, set labels and maze bits.
  logic [CFG_W-1:0] rows_cfg;
  logic [CFG_W-1:0] cols_cfg;
  logic [9:0] set_of [0:MAX_ROWS*MAX_COLS-1];
  logic maze_walls [0:MAZE_W*MAZE_H-1];

  carve_req_t pending_reqs[$];
  kmc_res_t owed_results[$];

  int unsigned faults = 0;
  int unsigned results_seen = 0;
  int unsigned random_reqs = 0;
  int unsigned n_merge = 0, n_refused = 0, n_off_grid = 0;
  int unsigned n_read = 0, n_read_out = 0, n_init = 0, n_spare = 0;
  int unsigned pressure_asks = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  logic no_idle = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void wipe_store();
    for (int i = 0; i < MAX_ROWS * MAX_COLS; i++) set_of[i] = 10'(i);
    for (int i = 0; i < MAZE_W * MAZE_H; i++) maze_walls[i] = 1'b1;
  endfunction

  // Zero counts as one, anything past the grid limit as the limit.
  function automatic int unsigned dim_in_use(logic [CFG_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Predicts the result of one request and updates the shadow store.
  function automatic kmc_res_t carve_step(carve_req_t rq);
    kmc_res_t r;
    int unsigned nrow, ncol, rr, cc, nr, nc, y, x;
    logic [9:0] keep, gone;
    r = '0;
    r.status = ST_OK;
    nrow = dim_in_use(rows_cfg, MAX_ROWS);
    ncol = dim_in_use(cols_cfg, MAX_COLS);
    case (rq.req)
      REQ_INIT: begin
        wipe_store();
        n_init++;
      end
      REQ_EDGE: begin
        rr = rq.row;
        cc = rq.col;
        nr = rr + (rq.down ? 1 : 0);
        nc = cc + (rq.down ? 0 : 1);
        if (rr >= nrow || cc >= ncol || nr >= nrow || nc >= ncol) begin
          r.status = ST_EDGE_OUT;
          n_off_grid++;
        end else begin
          keep = set_of[rr * MAX_COLS + cc];
          gone = set_of[nr * MAX_COLS + nc];
          if (keep != gone) begin
            // Only cells of the grid in use take part in the relabel.
            for (int i = 0; i < nrow; i++)
              for (int j = 0; j < ncol; j++)
                if (set_of[i * MAX_COLS + j] == gone) set_of[i * MAX_COLS + j] = keep;
            y = 2 * rr + 1;
            x = 2 * cc + 1;
            for (int i = 0; i < CARVE_LEN; i++) begin
              if (rq.down) maze_walls[(y + i) * MAZE_W + x] = 1'b0;
              else maze_walls[y * MAZE_W + x + i] = 1'b0;
            end
            r.accepted = 1'b1;
            n_merge++;
          end else begin
            n_refused++;
          end
        end
      end
      REQ_READ: begin
        y = rq.gy;
        x = rq.gx;
        n_read++;
        if (y >= 2 * nrow + 1 || x >= 2 * ncol + 1) begin
          r.status = ST_READ_OUT;
          n_read_out++;
        end else begin
          r.cell_value = maze_walls[y * MAZE_W + x];
        end
      end
      default: n_spare++;
    endcase
    return r;
  endfunction

  // Mostly short gaps, now and then a long one, none in a busy phase.
  function automatic int unsigned pick_gap();
    int unsigned p;
    if (no_idle) return 0;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic log_fault(input string msg);
    faults++;
    if (faults <= 10) $display("%s", msg);
  endtask

  // Request driver: takes the next pending request and holds it until the block accepts it.
  int unsigned send_gap = 0;
  carve_req_t cur_req;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_tvalid && in_tready)
        owed_results.insert(owed_results.size(), carve_step(cur_req));
      if (in_tvalid && !in_tready) begin
        in_tvalid <= 1'b1;
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        cur_req <= pending_reqs[0];
        in_tdata <= {7'd0, pending_reqs[0].gx, pending_reqs[0].gy, pending_reqs[0].down,
                     pending_reqs[0].col, pending_reqs[0].row};
        in_tuser <= pending_reqs[0].req;
        in_tvalid <= 1'b1;
        send_gap <= pick_gap();
        void'(pending_reqs.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so the block backs up into its input queue.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      holds_done <= 0;
    end else if (holds_done != pressure_asks) begin
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: checks each accepted result against the oldest prediction.
  int unsigned recv_gap = 0;
  always @(posedge clk) begin : result_check
    kmc_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (owed_results.size() == 0) begin
          log_fault($sformatf("result %0d arrived with nothing pending: tdata %h tuser %0d",
                              results_seen, out_tdata, out_tuser));
        end else begin
          want = owed_results.pop_front();
          if (out_tdata[0] !== want.accepted || out_tdata[1] !== want.cell_value ||
              out_tuser !== want.status)
            log_fault($sformatf({"result %0d: expected accepted %0d value %0d status %0d,",
                                 " got accepted %0d value %0d status %0d"},
                                results_seen, want.accepted, want.cell_value, want.status,
                                out_tdata[0], out_tdata[1], out_tuser));
        end
        results_seen++;
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  task automatic add_req(input logic [1:0] req, input int unsigned row, input int unsigned col,
                         input logic down, input int unsigned gy, input int unsigned gx);
    carve_req_t rq;
    rq.req = req;
    rq.row = 5'(row);
    rq.col = 5'(col);
    rq.down = down;
    rq.gy = 7'(gy);
    rq.gx = 7'(gx);
    pending_reqs.insert(pending_reqs.size(), rq);
  endtask

  // Waits until every request went out and every result came back, then lets the block settle.
  task automatic wait_idle(input int unsigned settle);
    while (pending_reqs.size() != 0 || in_tvalid || owed_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Register writes happen only while the block is idle; the shadow follows on the handshake.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ROWS) rows_cfg = val;
    else if (idx == CFG_COLS) cols_cfg = val;
    @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_dim();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 65) return CFG_W'($urandom_range(1, 6));
    if (p < 73) return '0;
    if (p < 81) return CFG_W'(MAX_ROWS);
    if (p < 88) return '1;
    return CFG_W'($urandom_range(0, 63));
  endfunction

  // One random phase: mostly edges and reads inside the grid in use, some noise.
  task automatic run_phase(input int unsigned count, input bit start_fresh);
    carve_req_t rq;
    int unsigned p, nrow, ncol;
    nrow = dim_in_use(rows_cfg, MAX_ROWS);
    ncol = dim_in_use(cols_cfg, MAX_COLS);
    if (start_fresh) add_req(REQ_INIT, $urandom_range(31), $urandom_range(31),
                             1'($urandom_range(1)), $urandom_range(127), $urandom_range(127));
    repeat (count) begin
      rq.row = 5'($urandom_range(31));
      rq.col = 5'($urandom_range(31));
      rq.down = 1'($urandom_range(1));
      rq.gy = 7'($urandom_range(127));
      rq.gx = 7'($urandom_range(127));
      p = $urandom_range(99);
      if (p < 55) begin
        rq.req = REQ_EDGE;
        rq.row = 5'($urandom_range(nrow - 1));
        rq.col = 5'($urandom_range(ncol - 1));
      end else if (p < 80) begin
        rq.req = REQ_READ;
        rq.gy = 7'($urandom_range(2 * nrow));
        rq.gx = 7'($urandom_range(2 * ncol));
      end else if (p < 88) begin
        rq.req = REQ_EDGE;
      end else if (p < 95) begin
        rq.req = REQ_READ;
      end else if (p < 98) begin
        rq.req = REQ_SPARE;
      end else begin
        rq.req = REQ_INIT;
      end
      pending_reqs.insert(pending_reqs.size(), rq);
      if (rq.req != REQ_SPARE) random_reqs++;
    end
    wait_idle(12);
  endtask

  initial begin : stimulus
    int unsigned phases;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ROWS;
    cfg_data = '0;
    rows_cfg = DIM_RESET;
    cols_cfg = DIM_RESET;
    wipe_store();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Grid left at its reset size: corners, reads past the maze, merges, a refused edge,
    // edges off the grid, the ignored request code and a re-initialization.
    add_req(REQ_READ, 0, 0, 1'b0, 0, 0);
    add_req(REQ_READ, 0, 0, 1'b0, 62, 62);
    add_req(REQ_READ, 0, 0, 1'b0, 63, 5);
    add_req(REQ_READ, 31, 31, 1'b1, 127, 127);
    add_req(REQ_EDGE, 0, 0, 1'b0, 0, 0);
    add_req(REQ_EDGE, 0, 1, 1'b1, 0, 0);
    add_req(REQ_EDGE, 0, 0, 1'b1, 0, 0);
    add_req(REQ_EDGE, 1, 0, 1'b0, 0, 0);
    add_req(REQ_EDGE, 30, 30, 1'b0, 0, 0);
    add_req(REQ_EDGE, 31, 0, 1'b0, 0, 0);
    add_req(REQ_EDGE, 29, 30, 1'b1, 0, 0);
    add_req(REQ_READ, 0, 0, 1'b0, 1, 2);
    add_req(REQ_READ, 0, 0, 1'b0, 2, 1);
    add_req(REQ_SPARE, 31, 31, 1'b1, 127, 127);
    add_req(REQ_INIT, 0, 0, 1'b0, 0, 0);
    add_req(REQ_READ, 0, 0, 1'b0, 1, 2);
    wait_idle(12);

    // Zero-sized grid counts as a single cell; writes to unused indexes must do nothing.
    write_reg(CFG_ROWS, '0);
    write_reg(CFG_COLS, '0);
    write_reg(CFG_SPARE_LO, 6'h2a);
    write_reg(CFG_SPARE_HI, 6'h15);
    add_req(REQ_EDGE, 0, 0, 1'b0, 0, 0);
    add_req(REQ_EDGE, 0, 0, 1'b1, 0, 0);
    add_req(REQ_READ, 0, 0, 1'b0, 2, 2);
    add_req(REQ_READ, 0, 0, 1'b0, 3, 0);
    add_req(REQ_READ, 0, 0, 1'b0, 0, 3);
    wait_idle(12);

    // Largest grid, once exactly and once through clamping.
    write_reg(CFG_ROWS, '1);
    write_reg(CFG_COLS, CFG_W'(MAX_COLS));
    add_req(REQ_EDGE, 31, 30, 1'b0, 0, 0);
    add_req(REQ_EDGE, 30, 31, 1'b1, 0, 0);
    add_req(REQ_EDGE, 31, 31, 1'b1, 0, 0);
    add_req(REQ_READ, 0, 0, 1'b0, 64, 64);
    add_req(REQ_READ, 0, 0, 1'b0, 65, 0);
    wait_idle(12);
    phases = 3;

    // Random phases, each under a fresh grid size.
    while (random_reqs < RAND_TARGET) begin
      write_reg(CFG_ROWS, pick_dim());
      write_reg(CFG_COLS, pick_dim());
      no_idle <= ($urandom_range(3) == 0);
      if (phases == 3 || $urandom_range(7) == 0) pressure_asks <= pressure_asks + 1;
      run_phase($urandom_range(15, 50), 1'($urandom_range(1)));
      phases++;
    end

    wait_idle(50);
    $display("Ran %0d requests over %0d grid settings, %0d results checked.",
             n_merge + n_refused + n_off_grid + n_read + n_init + n_spare, phases,
             results_seen);
    $display("Merges %0d, refused %0d, off grid %0d, reads %0d (%0d outside), inits %0d.",
             n_merge, n_refused, n_off_grid, n_read, n_read_out, n_init);
    if (faults == 0 && owed_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Covers the worst case: every request a full clearing pass plus the longest stalls.
  initial begin
    #(64'd200_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
